// ===== rtl/solt_pkg.sv =====
// ----------------------------------------------------------------------------
// solt_pkg: shared definitions for the self-organizing lookup table
// Table geometry, field widths, register and policy codes, the stored entry
// layout and the saturating count increment.
// ----------------------------------------------------------------------------
`default_nettype none

package solt_pkg;

  // Table geometry.
  localparam int unsigned ENTRIES = 1024;
  localparam int unsigned AW      = $clog2(ENTRIES);

  // Field widths.
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned POS_W      = 10;
  localparam int unsigned POL_W      = 2;
  localparam int unsigned ACT_W      = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 2'd1;

  // Reset value of the active entry count.
  localparam logic [ACT_W-1:0] ACTIVE_RST = 11'd1024;

  // Reorganization policies.
  localparam logic [POL_W-1:0] POL_COUNT     = 2'd0;
  localparam logic [POL_W-1:0] POL_TO_FRONT  = 2'd1;
  localparam logic [POL_W-1:0] POL_TRANSPOSE = 2'd2;
  localparam logic [POL_W-1:0] POL_GUARDED   = 2'd3;

  // Load and search item modes.
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  // Operations of the shared compare unit.
  typedef enum logic {
    CMP_EQ,
    CMP_GT
  } cmp_op_e;

  // One stored table entry: key and its hit count move together.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] cnt;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Saturating increment of a hit count.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/solt_in_if.sv =====
// ----------------------------------------------------------------------------
// solt_in_if: input item channel
// Valid/ready channel that carries one load or search item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface solt_in_if;
  import solt_pkg::*;

  logic             valid;
  logic             ready;
  logic             mode;
  logic [IDX_W-1:0] index;
  logic [KEY_W-1:0] key;

  modport source (output valid, output mode, output index, output key, input ready);
  modport sink   (input valid, input mode, input index, input key, output ready);
endinterface

`default_nettype wire

// ===== rtl/solt_out_if.sv =====
// ----------------------------------------------------------------------------
// solt_out_if: result channel
// Valid/ready channel that carries one result per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface solt_out_if;
  import solt_pkg::*;

  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] position;

  modport source (output valid, output found, output position, input ready);
  modport sink   (input valid, input found, input position, output ready);
endinterface

`default_nettype wire

// ===== rtl/solt_ram.sv =====
// ----------------------------------------------------------------------------
// solt_ram: generic single-port-write, single-port-read memory
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module solt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/solt_cmp.sv =====
// ----------------------------------------------------------------------------
// solt_cmp: shared compare unit
// Key equality during the scan and hit count ordering for the guarded swap.
// ----------------------------------------------------------------------------
`default_nettype none

module solt_cmp (
  input  wire solt_pkg::cmp_op_e          op_i,
  input  wire logic [solt_pkg::KEY_W-1:0] a_i,
  input  wire logic [solt_pkg::KEY_W-1:0] b_i,
  output logic                            res_o
);
  import solt_pkg::*;

  // One 32-bit comparator, selected by the sequencer.
  always_comb begin
    case (op_i)
      CMP_EQ:  res_o = (a_i == b_i);
      CMP_GT:  res_o = (a_i > b_i);
      default: res_o = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/self_organizing_lookup_table.sv =====
// ----------------------------------------------------------------------------
// self_organizing_lookup_table: keyed table that reorders itself on hits
// A load or a search over an empty range goes straight to its result; a search
// scans up to min(active_entries, ENTRIES) entries, and a hit only updates its
// count when the policy only counts or it sits at position zero, is rewritten
// in place when the guard keeps it, or else is swapped. One item is in work at a
// time and the next transfer can share the edge of the result transfer.
// Reset: a clearing pass zeroes every table entry; no item is taken
// until it ends, while configuration writes are taken at all times.
// ----------------------------------------------------------------------------
`default_nettype none

module self_organizing_lookup_table (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [solt_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [solt_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  solt_in_if.sink                                 in_i,
  solt_out_if.source                              out_o
);
  import solt_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_OTH   = 3'd3;
  localparam logic [2:0] S_OTHW  = 3'd4;
  localparam logic [2:0] S_WR2   = 3'd5;
  localparam logic [2:0] S_WRHIT = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);

  logic [2:0]       state_q, state_d;
  logic [POL_W-1:0] policy_q;
  logic [ACT_W-1:0] active_q;
  logic [AW-1:0]    ptr_q, ptr_d;
  logic [AW-1:0]    cmp_ptr_q, cmp_ptr_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic             out_vld_q, out_vld_d;

  logic [KEY_W-1:0] key_q, key_d;
  logic [AW-1:0]    last_q, last_d;
  logic [AW-1:0]    hit_pos_q, hit_pos_d;
  logic [AW-1:0]    oth_q, oth_d;
  logic [CNT_W-1:0] hit_cnt_q, hit_cnt_d;
  logic             res_found_q, res_found_d;
  logic             found_q, found_d;
  logic [POS_W-1:0] pos_q, pos_d;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  entry_t           ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t           rd_entry;

  cmp_op_e          cmp_op;
  logic [KEY_W-1:0] cmp_a;
  logic [KEY_W-1:0] cmp_b;
  logic             cmp_res;

  logic             in_xfer;
  logic             slot_free;
  logic             do_swap;
  logic [31:0]      limit;
  entry_t           hit_entry;

  assign in_xfer   = in_i.valid && in_i.ready;
  assign slot_free = !out_vld_q || out_o.ready;
  assign rd_entry  = entry_t'(ram_rdata);
  assign hit_entry = '{key: key_q, cnt: sat_inc(hit_cnt_q)};
  assign limit     = (32'(active_q) > ENTRIES) ? ENTRIES : 32'(active_q);
  assign do_swap   = (policy_q != POL_GUARDED) || cmp_res;

  assign in_i.ready     = (state_q == S_IDLE);
  assign out_o.valid    = out_vld_q;
  assign out_o.found    = found_q;
  assign out_o.position = pos_q;

  // Table storage: key and hit count of each entry in one word.
  solt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Shared comparator: key match while scanning, count order for the guard.
  always_comb begin
    if (state_q == S_OTHW) begin
      cmp_op = CMP_GT;
      cmp_a  = hit_cnt_q;
      cmp_b  = rd_entry.cnt;
    end else begin
      cmp_op = CMP_EQ;
      cmp_a  = key_q;
      cmp_b  = rd_entry.key;
    end
  end

  solt_cmp u_cmp (
    .op_i  (cmp_op),
    .a_i   (cmp_a),
    .b_i   (cmp_b),
    .res_o (cmp_res)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_COUNT;
      active_q <= ACTIVE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_POLICY: policy_q <= cfg_data_i[POL_W-1:0];
        REG_ACTIVE: active_q <= cfg_data_i[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: clearing pass, scan, reorganizing writes and result hand-off.
  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    cmp_ptr_d   = cmp_ptr_q;
    cmp_vld_d   = cmp_vld_q;
    key_d       = key_q;
    last_d      = last_q;
    hit_pos_d   = hit_pos_q;
    oth_d       = oth_q;
    hit_cnt_d   = hit_cnt_q;
    res_found_d = res_found_q;
    found_d     = found_q;
    pos_d       = pos_q;
    out_vld_d   = out_vld_q && !out_o.ready;
    ram_we      = 1'b0;
    ram_waddr   = hit_pos_q;
    ram_wdata   = hit_entry;
    ram_raddr   = ptr_q;

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ram_wdata = '0;
        ptr_d     = ptr_q + 1'b1;
        if (ptr_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_xfer) begin
          key_d       = in_i.key;
          hit_pos_d   = '0;
          res_found_d = 1'b0;
          ptr_d       = '0;
          cmp_vld_d   = 1'b0;
          last_d      = AW'(limit - 32'd1);
          if (in_i.mode == MODE_LOAD) begin
            // A load writes the key with a cleared count.
            if (32'(in_i.index) < ENTRIES) begin
              ram_we    = 1'b1;
              ram_waddr = AW'(in_i.index);
              ram_wdata = '{key: in_i.key, cnt: '0};
            end
            state_d = S_FIN;
          end else if (limit == 32'd0) begin
            state_d = S_FIN;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Reads run one entry ahead of the compare.
        ptr_d     = ptr_q + 1'b1;
        cmp_ptr_d = ptr_q;
        cmp_vld_d = 1'b1;
        if (cmp_vld_q) begin
          if (cmp_res) begin
            res_found_d = 1'b1;
            hit_pos_d   = cmp_ptr_q;
            hit_cnt_d   = rd_entry.cnt;
            oth_d       = (policy_q == POL_TO_FRONT) ? '0 : cmp_ptr_q - 1'b1;
            if ((policy_q == POL_COUNT) || (cmp_ptr_q == '0)) begin
              state_d = S_WRHIT;
            end else begin
              state_d = S_OTH;
            end
          end else if (cmp_ptr_q == last_q) begin
            state_d = S_FIN;
          end
        end
      end

      S_OTH: begin
        // Fetch the entry that the hit entry may trade places with.
        ram_raddr = oth_q;
        state_d   = S_OTHW;
      end

      S_OTHW: begin
        ram_we    = 1'b1;
        ram_waddr = hit_pos_q;
        if (do_swap) begin
          ram_wdata = rd_entry;
          state_d   = S_WR2;
        end else begin
          ram_wdata = hit_entry;
          state_d   = S_FIN;
        end
      end

      S_WR2: begin
        ram_we    = 1'b1;
        ram_waddr = oth_q;
        ram_wdata = hit_entry;
        state_d   = S_FIN;
      end

      S_WRHIT: begin
        ram_we    = 1'b1;
        ram_waddr = hit_pos_q;
        ram_wdata = hit_entry;
        state_d   = S_FIN;
      end

      S_FIN: begin
        if (slot_free) begin
          out_vld_d = 1'b1;
          found_d   = res_found_q;
          pos_d     = POS_W'(hit_pos_q);
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      ptr_q     <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      cmp_vld_q <= cmp_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmp_ptr_q   <= cmp_ptr_d;
    key_q       <= key_d;
    last_q      <= last_d;
    hit_pos_q   <= hit_pos_d;
    oth_q       <= oth_d;
    hit_cnt_q   <= hit_cnt_d;
    res_found_q <= res_found_d;
    found_q     <= found_d;
    pos_q       <= pos_d;
  end

  // The scan only reads; the table is never written while entries are compared.
  a_scan_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !ram_we)
    else $error("table written during scan");

  // The clearing pass ends after its last entry and opens the input.
  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) && (ptr_q == LAST_ADDR) |=> (state_q == S_IDLE))
    else $error("clearing pass did not end");

  // A finished item posts its result once the output slot is free.
  a_fin_posts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) && slot_free |=> out_vld_q && (state_q == S_IDLE))
    else $error("result not posted");

  // A search over a nonempty range starts the scan.
  a_search_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_i.mode == MODE_SEARCH) && (limit != 32'd0) |=> (state_q == S_SCAN))
    else $error("search did not start scan");

  // A hit reported by the scan never lies beyond the last active entry.
  a_hit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) && cmp_vld_q && cmp_res |-> (cmp_ptr_q <= last_q))
    else $error("hit beyond active range");

endmodule

`default_nettype wire
